### rtl/core/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg: shared constants and types for the 4x4 fixed-point matrix inverse
// Holds default widths, the width of the exact intermediate words and the
// arithmetic-unit operation codes.
// ----------------------------------------------------------------------------
package mi4_pkg;

  localparam int unsigned FractionBitsDefault = 16;
  localparam int unsigned ElemW  = 32;
  localparam int unsigned NumElem = 16;
  localparam int unsigned IdxW   = 4;
  // Cofactor: 3 x 32-bit product plus sum growth; determinant: 4 x 32 plus growth.
  localparam int unsigned CofW   = 100;
  localparam int unsigned DetW   = 132;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,   // acc = product
    OP_ADD  = 2'd1,   // acc = acc + product
    OP_SUB  = 2'd2    // acc = acc - product
  } alu_op_e;

  // Multiply-accumulate request from the sequencer.
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } mac_ctrl_t;

endpackage

### rtl/core/mi4_mac.sv
// ----------------------------------------------------------------------------
// mi4_mac: shared signed multiply-accumulate unit
// Multiplies a 32-bit operand with a wide operand in 32-bit chunks, one partial
// product per cycle, then loads, adds or subtracts the result into the accumulator.
// ----------------------------------------------------------------------------
module mi4_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mi4_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [mi4_pkg::ElemW-1:0]  a_i,
  input  logic signed [mi4_pkg::DetW-1:0]   b_i,
  input  logic signed [mi4_pkg::DetW-1:0]   acc_in_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [mi4_pkg::DetW-1:0]   acc_o
);

  localparam int unsigned DW = mi4_pkg::DetW;
  localparam int unsigned NChunk = (DW + 31) / 32;
  localparam int unsigned PadW = NChunk * 32;
  localparam int unsigned CntW = $clog2(NChunk + 1);

  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic                      neg_q, neg_d;
  logic [31:0]               ma_q, ma_d;
  logic [PadW-1:0]           mb_q, mb_d;
  logic [DW-1:0]             prod_q, prod_d;
  logic signed [DW-1:0]      acc_q, acc_d;
  mi4_pkg::alu_op_e          op_q, op_d;
  logic [63:0]               pp;
  logic [31:0]               chunk;
  logic signed [DW-1:0]      sprod;

  always_comb begin
    chunk = mb_q[cnt_q[CntW-1:0]*32 +: 32];
    pp    = {32'd0, ma_q} * {32'd0, chunk};
    sprod = neg_q ? -$signed(prod_q) : $signed(prod_q);
  end

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0; neg_d = neg_q;
    ma_d = ma_q; mb_d = mb_q; prod_d = prod_q; acc_d = acc_q; op_d = op_q;
    if (ctrl_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = ctrl_i.op;
      neg_d  = a_i[mi4_pkg::ElemW-1] ^ b_i[DW-1];
      ma_d   = a_i[mi4_pkg::ElemW-1] ? 32'(-a_i) : 32'(a_i);
      mb_d   = PadW'(b_i[DW-1] ? DW'(-b_i) : DW'(b_i));
      prod_d = '0;
      acc_d  = acc_in_i;
    end else if (busy_q) begin
      if (cnt_q == CntW'(NChunk)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        case (op_q)
          mi4_pkg::OP_LOAD: acc_d = sprod;
          mi4_pkg::OP_ADD:  acc_d = acc_q + sprod;
          mi4_pkg::OP_SUB:  acc_d = acc_q - sprod;
          default:          acc_d = sprod;
        endcase
      end else begin
        prod_d = prod_q + DW'({{(PadW){1'b0}}, pp} << (cnt_q * 32));
        cnt_d  = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; ma_q <= ma_d; mb_q <= mb_d;
    prod_q <= prod_d; acc_q <= acc_d; op_q <= op_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

### rtl/core/mi4_div.sv
// ----------------------------------------------------------------------------
// mi4_div: restoring divider for one inverse element
// Computes round(|A| * 2^(2F) / |D|), one quotient bit per cycle, then signs
// and saturates to 32 bits.
// ----------------------------------------------------------------------------
module mi4_div #(
  parameter int unsigned FRACTION_BITS = mi4_pkg::FractionBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [mi4_pkg::CofW-1:0]   cof_i,
  input  logic signed [mi4_pkg::DetW-1:0]   det_i,
  output logic                              done_o,
  output logic [mi4_pkg::ElemW-1:0]         value_o,
  output logic                              sat_o
);

  localparam int unsigned NW = mi4_pkg::CofW + 2 * FRACTION_BITS;
  localparam int unsigned RW = mi4_pkg::DetW + 1;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]  num_q, quo_q;
  logic [RW-1:0]  rem_q, dmag_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q, neg_q;
  logic [RW-1:0]  rem_sh, rem_sub;
  logic [NW:0]    qr;
  logic           big, sat;
  logic [31:0]    val;

  assign rem_sh  = {rem_q[RW-2:0], num_q[NW-1]};
  assign rem_sub = rem_sh - dmag_q;

  always_comb begin
    qr  = {1'b0, quo_q} + (NW+1)'(({rem_q, 1'b0} >= {1'b0, dmag_q}) ? 1 : 0);
    big = |qr[NW:32];
    sat = 1'b0;
    if (neg_q) begin
      if (big || qr[31:0] > 32'h8000_0000) begin val = 32'h8000_0000; sat = 1'b1; end
      else val = 32'd0 - qr[31:0];
    end else begin
      if (big || qr[31:0] > 32'h7FFF_FFFF) begin val = 32'h7FFF_FFFF; sat = 1'b1; end
      else val = qr[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      neg_q  <= cof_i[mi4_pkg::CofW-1] ^ det_i[mi4_pkg::DetW-1];
      num_q  <= NW'(cof_i[mi4_pkg::CofW-1] ? -cof_i : cof_i) << (2 * FRACTION_BITS);
      dmag_q <= RW'(det_i[mi4_pkg::DetW-1] ? -det_i : det_i);
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q && cnt_q != '0) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      if (rem_sh >= dmag_q) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
    if (busy_q && cnt_q == '0) begin
      value_o <= val;
      sat_o   <= sat;
    end
  end

  assign done_o = done_q;

endmodule

### rtl/core/matrix_inverse_4x4_top.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_top: 4x4 fixed-point matrix inverse by cofactors
// Sequencer, element store and result register around a shared MAC and divider.
// ----------------------------------------------------------------------------
// Loading accepts one element per cycle. After the sixteenth element the block
// is busy: every cofactor is built from three terms, each two MAC passes for
// the 2x2 minor and one for the outer product on the shared multiplier, and
// further MAC passes then form the determinant. Each inverse element goes
// through the bit-serial divider (skipped for a singular matrix) and then an
// output step, where it waits until taken.
module matrix_inverse_4x4_top #(
  parameter int unsigned FRACTION_BITS = mi4_pkg::FractionBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mi4_pkg::ElemW-1:0]  element_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mi4_pkg::ElemW-1:0]  inverse_value_o,
  output logic [mi4_pkg::IdxW-1:0]          element_index_o,
  output logic                              last_element_o,
  output logic                              singular_o,
  output logic                              saturated_o
);

  localparam int unsigned DW = mi4_pkg::DetW;
  localparam int unsigned CW = mi4_pkg::CofW;

  typedef enum logic [3:0] {
    S_LOAD, S_PAIR, S_PAIR_W, S_TRIP, S_TRIP_W, S_COF_NEXT,
    S_DET, S_DET_W, S_DIV, S_DIV_W, S_OUT
  } state_e;

  state_e state_q;
  logic [31:0]          mem_q [16];
  logic signed [CW-1:0] adj_q [16];
  logic [3:0]           load_cnt_q, cof_q, elem_q;
  logic [1:0]           term_q, det_cnt_q;
  logic signed [DW-1:0] tri_q, det_q;
  logic                 sing_q;

  mi4_pkg::mac_ctrl_t   mac_ctrl;
  logic signed [31:0]   mac_a;
  logic signed [DW-1:0] mac_b, mac_acc_in, mac_acc;
  logic                 mac_busy, mac_done, div_start, div_done, div_sat;
  logic [31:0]          div_val;

  // cofactor index cof = r*4+c uses minor deleting row c, column r
  logic [1:0] sr, sc, r0, r1, r2, c0, c1, c2, ca, cb, cx;
  always_comb begin
    sr = cof_q[1:0];
    sc = cof_q[3:2];
    r0 = (sr == 2'd0) ? 2'd1 : 2'd0;
    r1 = (sr <= 2'd1) ? 2'd2 : 2'd1;
    r2 = (sr == 2'd3) ? 2'd2 : 2'd3;
    c0 = (sc == 2'd0) ? 2'd1 : 2'd0;
    c1 = (sc <= 2'd1) ? 2'd2 : 2'd1;
    c2 = (sc == 2'd3) ? 2'd2 : 2'd3;
    // term 0: e00*(e11e22-e12e21); term 1: e01*(e10e22-e12e20); term 2: e02*(e10e21-e11e20)
    case (term_q)
      2'd0:    begin cx = c0; ca = c1; cb = c2; end
      2'd1:    begin cx = c1; ca = c0; cb = c2; end
      default: begin cx = c2; ca = c0; cb = c1; end
    endcase
  end

  // two-step pair: tri = e1a*e2b (LOAD), tri -= e1b*e2a, then acc +=/-= e0x*tri
  logic pair_ph_q;
  always_comb begin
    mac_ctrl.start = 1'b0;
    mac_ctrl.op    = mi4_pkg::OP_LOAD;
    mac_a = '0; mac_b = '0; mac_acc_in = tri_q;
    case (state_q)
      S_PAIR: begin
        mac_ctrl.start = 1'b1;
        mac_ctrl.op = pair_ph_q ? mi4_pkg::OP_SUB : mi4_pkg::OP_LOAD;
        mac_a = pair_ph_q ? $signed(mem_q[{r1, cb}]) : $signed(mem_q[{r1, ca}]);
        mac_b = pair_ph_q ? DW'($signed(mem_q[{r2, ca}])) : DW'($signed(mem_q[{r2, cb}]));
        mac_acc_in = tri_q;
      end
      S_TRIP: begin
        mac_ctrl.start = 1'b1;
        mac_ctrl.op = (term_q == 2'd1) ? mi4_pkg::OP_SUB : mi4_pkg::OP_ADD;
        mac_a = $signed(mem_q[{r0, cx}]);
        mac_b = tri_q;
        mac_acc_in = (term_q == 2'd0) ? '0 : DW'(adj_q[cof_q]);
      end
      S_DET: begin
        mac_ctrl.start = 1'b1;
        mac_ctrl.op = mi4_pkg::OP_ADD;
        mac_a = $signed(mem_q[{2'd0, det_cnt_q}]);
        mac_b = DW'(adj_q[{det_cnt_q, 2'd0}]);
        mac_acc_in = det_q;
      end
      default: ;
    endcase
  end

  mi4_mac u_mac (
    .clk_i, .rst_ni, .ctrl_i(mac_ctrl), .a_i(mac_a), .b_i(mac_b),
    .acc_in_i(mac_acc_in), .busy_o(mac_busy), .done_o(mac_done), .acc_o(mac_acc)
  );

  assign div_start = (state_q == S_DIV) && !sing_q;

  mi4_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .cof_i(adj_q[elem_q]), .det_i(det_q),
    .done_o(div_done), .value_o(div_val), .sat_o(div_sat)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[load_cnt_q] <= element_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      load_cnt_q <= '0; cof_q <= '0; elem_q <= '0; term_q <= '0;
      det_cnt_q <= '0; pair_ph_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: if (in_valid_i) begin
          load_cnt_q <= load_cnt_q + 1'b1;
          if (load_cnt_q == 4'd15) begin
            state_q <= S_PAIR; cof_q <= '0; term_q <= '0; pair_ph_q <= 1'b0;
          end
        end
        S_PAIR: state_q <= S_PAIR_W;
        S_PAIR_W: if (mac_done) begin
          tri_q <= mac_acc;
          pair_ph_q <= ~pair_ph_q;
          state_q <= pair_ph_q ? S_TRIP : S_PAIR;
        end
        S_TRIP: state_q <= S_TRIP_W;
        S_TRIP_W: if (mac_done) begin
          if (term_q == 2'd2) begin
            adj_q[cof_q] <= (sr[0] ^ sc[0]) ? -CW'(mac_acc) : CW'(mac_acc);
            term_q <= '0;
            state_q <= S_COF_NEXT;
          end else begin
            adj_q[cof_q] <= CW'(mac_acc);
            term_q <= term_q + 1'b1;
            state_q <= S_PAIR;
          end
        end
        S_COF_NEXT: begin
          cof_q <= cof_q + 1'b1;
          if (cof_q == 4'd15) begin
            state_q <= S_DET; det_cnt_q <= '0; det_q <= '0;
          end else state_q <= S_PAIR;
        end
        S_DET: state_q <= S_DET_W;
        S_DET_W: if (mac_done) begin
          det_q <= mac_acc;
          det_cnt_q <= det_cnt_q + 1'b1;
          if (det_cnt_q == 2'd3) begin
            state_q <= S_DIV; elem_q <= '0;
            sing_q <= (mac_acc == '0);
          end else state_q <= S_DET;
        end
        S_DIV: state_q <= sing_q ? S_OUT : S_DIV_W;
        S_DIV_W: if (div_done) state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_o) begin
            out_valid_o <= 1'b1;
            inverse_value_o <= sing_q ? '0 : $signed(div_val);
            saturated_o <= sing_q ? 1'b0 : div_sat;
            singular_o <= sing_q;
            element_index_o <= elem_q;
            last_element_o <= (elem_q == 4'd15);
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            elem_q <= elem_q + 1'b1;
            state_q <= (elem_q == 4'd15) ? S_LOAD : S_DIV;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_LOAD);

  ap_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready while result pending");
  ap_mac_idle_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mac_busy) else $error("mac busy during load");
  ap_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |-> (inverse_value_o == '0 && !saturated_o))
    else $error("singular output not zero");

endmodule
